// ===== src/gcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_pkg: shared types and constants for the grid min-cost path core
// Field widths, configuration register codes and the per-cell flags that
// travel from the front end to the back end.
// ----------------------------------------------------------------------------
package gcp_pkg;

	// Field widths
	localparam int COST_W     = 16;
	localparam int SUM_W      = 32;
	localparam int ROWS_CFG_W = 11;
	localparam int COLS_CFG_W = 9;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} cfg_reg_t;

	// Position class of one cell
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic last_cell;
	} cell_flags_t;

endpackage

`default_nettype wire

// ===== src/gcp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// while the read enable is low. A read of the address written in the same
// cycle returns the old contents.
// ----------------------------------------------------------------------------
module gcp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write, then registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/gcp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_queue: small register FIFO
// Circular buffer with push/full on the write side and pop/empty on the
// read side; the oldest entry is shown on rdata while empty is low.
// ----------------------------------------------------------------------------
module gcp_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	localparam int AW    = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/gcp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_front: cell intake and position tracking
// Accepts cells, tracks the raster position against the configured grid
// size and tags each cell with its column and position class.
// ----------------------------------------------------------------------------
module gcp_front import gcp_pkg::*; #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire logic                        q_full,
	input  wire logic signed [COST_W-1:0]    cell_cost,
	input  wire logic [ROWS_CFG_W-1:0]       grid_rows,
	input  wire logic [COLS_CFG_W-1:0]       grid_cols,
	output logic                             item_push,
	output cell_flags_t                      item_flags,
	output logic [$clog2(MAX_COLS)-1:0]      item_col,
	output logic signed [COST_W-1:0]         item_cost
);

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int CCMP_W = (COLS_CFG_W > COL_W + 1) ? COLS_CFG_W : COL_W + 1;
	localparam int RCMP_W = (ROWS_CFG_W > ROW_W + 1) ? ROWS_CFG_W : ROW_W + 1;

	logic [COL_W-1:0]  col_pos_q;
	logic [ROW_W-1:0]  row_pos_q;
	logic [CCMP_W-1:0] cols_cfg;
	logic [CCMP_W-1:0] cols_eff;
	logic [RCMP_W-1:0] rows_cfg;
	logic [RCMP_W-1:0] rows_eff;
	logic              last_col;
	logic              last_row;
	logic              accept;

	// Saturate sizes at the bounds; a size of zero ends every row at once,
	// which is the same as a size of one
	assign cols_cfg = CCMP_W'(grid_cols);
	assign rows_cfg = RCMP_W'(grid_rows);
	assign cols_eff = (cols_cfg > CCMP_W'(MAX_COLS)) ? CCMP_W'(MAX_COLS) : cols_cfg;
	assign rows_eff = (rows_cfg > RCMP_W'(MAX_ROWS)) ? RCMP_W'(MAX_ROWS) : rows_cfg;

	assign last_col = (CCMP_W'(col_pos_q) + CCMP_W'(1)) >= cols_eff;
	assign last_row = (RCMP_W'(row_pos_q) + RCMP_W'(1)) >= rows_eff;
	assign accept   = push && !q_full;

	// Tag the cell for the back end
	assign item_push            = accept;
	assign item_flags.first_row = (row_pos_q == '0);
	assign item_flags.first_col = (col_pos_q == '0);
	assign item_flags.last_cell = last_col && last_row;
	assign item_col             = col_pos_q;
	assign item_cost            = cell_cost;

	// Advance the raster position; wrap at the end of a grid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_pos_q <= '0;
			row_pos_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_pos_q <= '0;
				row_pos_q <= last_row ? '0 : row_pos_q + ROW_W'(1);
			end else begin
				col_pos_q <= col_pos_q + COL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/gcp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_back: path-sum datapath with row buffer
// Reads the upper neighbor from the row buffer, takes the least of the left,
// upper and diagonal sums for inner cells, adds the cell cost, writes it back.
// The sum of the last cell of a grid goes out as a result.
// ----------------------------------------------------------------------------
module gcp_back import gcp_pkg::*; #(
	parameter int MAX_COLS = 256
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        head_valid,
	input  wire cell_flags_t                 head_flags,
	input  wire logic [$clog2(MAX_COLS)-1:0] head_col,
	input  wire logic signed [COST_W-1:0]    head_cost,
	output logic                             head_pop,
	input  wire logic                        res_full,
	output logic                             res_push,
	output logic signed [SUM_W-1:0]          res_sum
);

	localparam int COL_W = $clog2(MAX_COLS);

	logic                     valid_s1;
	cell_flags_t              flags_s1;
	logic [COL_W-1:0]         col_s1;
	logic signed [COST_W-1:0] cost_s1;
	logic                     fwd_s1;
	logic signed [SUM_W-1:0]  left_q;
	logic signed [SUM_W-1:0]  diag_q;
	logic signed [SUM_W-1:0]  ram_rdata;
	logic signed [SUM_W-1:0]  up_sum;
	logic signed [SUM_W-1:0]  min_lu;
	logic signed [SUM_W-1:0]  min_all;
	logic signed [SUM_W-1:0]  base_sum;
	logic signed [SUM_W-1:0]  new_sum;
	logic                     retire;
	logic                     advance;

	// Hold the last cell while the result queue is full
	assign retire   = valid_s1 && !(flags_s1.last_cell && res_full);
	assign advance  = head_valid && (!valid_s1 || retire);
	assign head_pop = advance;

	// Row buffer of best sums from the previous row
	gcp_ram #(
		.WIDTH (SUM_W),
		.DEPTH (MAX_COLS)
	) u_row_ram (
		.clk   (clk),
		.we    (retire),
		.waddr (col_s1),
		.wdata (new_sum),
		.re    (advance),
		.raddr (head_col),
		.rdata (ram_rdata)
	);

	// Bypass the sum written in the cycle of the read (single-column grid)
	assign up_sum  = fwd_s1 ? left_q : ram_rdata;
	assign min_lu  = (left_q < up_sum) ? left_q : up_sum;
	assign min_all = (min_lu < diag_q) ? min_lu : diag_q;

	always_comb begin
		if (flags_s1.first_row && flags_s1.first_col) begin
			base_sum = '0;
		end else if (flags_s1.first_row) begin
			base_sum = left_q;
		end else if (flags_s1.first_col) begin
			base_sum = up_sum;
		end else begin
			base_sum = min_all;
		end
	end

	assign new_sum  = base_sum + SUM_W'(cost_s1);
	assign res_push = retire && flags_s1.last_cell;
	assign res_sum  = new_sum;

	// Load the stage on advance; flag a read of the column being written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else if (advance) begin
			valid_s1 <= 1'b1;
			fwd_s1   <= retire && (head_col == col_s1);
		end else if (retire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			flags_s1 <= head_flags;
			col_s1   <= head_col;
			cost_s1  <= head_cost;
		end
	end

	// Update the left and diagonal neighbor sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
			diag_q <= '0;
		end else if (retire) begin
			left_q <= new_sum;
			diag_q <= up_sum;
		end
	end

endmodule

`default_nettype wire

// ===== src/grid_min_cost_path_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_min_cost_path_core: streaming least-cost grid path
// Cells of a cost grid enter in raster order; after the last cell the
// least path sum from top-left to bottom-right is returned.
// ----------------------------------------------------------------------------
// Push one cell per clock; the core sustains one cell per cycle while full is
// low. A result reaches min_cost through the intake queue, the datapath stage
// and the result queue after the last cell of a grid is accepted. The rate is
// set by the row buffer: each cell does one read and one write of the column's
// sum through a registered read, with a bypass for back-to-back access to the
// same column. A two-entry queue sits between intake and datapath, and another
// holds results, so the input stalls only when a finished answer waits behind
// a full result queue and the two-entry intake queue has filled up behind it.
// Set grid_rows and grid_cols while no grid is in flight; sizes saturate
// at MAX_ROWS and MAX_COLS, and a size of zero acts as one.
// ----------------------------------------------------------------------------
module grid_min_cost_path_core import gcp_pkg::*; #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire logic signed [COST_W-1:0] cell_cost,
	output logic                          empty,
	input  wire logic                     pop,
	output logic signed [SUM_W-1:0]       min_cost,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_wdata
);

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ITEM_W = $bits(cell_flags_t) + COL_W + COST_W;

	logic [ROWS_CFG_W-1:0]    grid_rows_q;
	logic [COLS_CFG_W-1:0]    grid_cols_q;

	logic                     item_push;
	cell_flags_t              item_flags;
	logic [COL_W-1:0]         item_col;
	logic signed [COST_W-1:0] item_cost;
	logic                     mid_full;
	logic                     mid_empty;
	logic [ITEM_W-1:0]        mid_rdata;
	logic                     head_pop;
	cell_flags_t              head_flags;
	logic [COL_W-1:0]         head_col;
	logic signed [COST_W-1:0] head_cost;
	logic                     res_full;
	logic                     res_push;
	logic signed [SUM_W-1:0]  res_sum;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= ROWS_CFG_W'(1);
			grid_cols_q <= COLS_CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_GRID_ROWS: grid_rows_q <= cfg_wdata[ROWS_CFG_W-1:0];
				REG_GRID_COLS: grid_cols_q <= cfg_wdata[COLS_CFG_W-1:0];
			endcase
		end
	end

	// Intake and position tracking
	gcp_front #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.q_full     (mid_full),
		.cell_cost  (cell_cost),
		.grid_rows  (grid_rows_q),
		.grid_cols  (grid_cols_q),
		.item_push  (item_push),
		.item_flags (item_flags),
		.item_col   (item_col),
		.item_cost  (item_cost)
	);

	assign full = mid_full;

	// Decoupling queue between intake and datapath
	gcp_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (2)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_push),
		.wdata  ({item_flags, item_col, item_cost}),
		.full   (mid_full),
		.pop    (head_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty)
	);

	assign {head_flags, head_col, head_cost} = mid_rdata;

	// Path-sum datapath
	gcp_back #(
		.MAX_COLS (MAX_COLS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (!mid_empty),
		.head_flags (head_flags),
		.head_col   (head_col),
		.head_cost  (head_cost),
		.head_pop   (head_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_sum    (res_sum)
	);

	// Result queue
	gcp_queue #(
		.WIDTH (SUM_W),
		.DEPTH (2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_sum),
		.full   (res_full),
		.pop    (pop),
		.rdata  (min_cost),
		.empty  (empty)
	);

endmodule

`default_nettype wire

// ===== src/gcp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gcp_checker: port-level checks for the grid min-cost path core
// Watches the cell and result queues from outside and flags ordering and
// back-pressure slips.
// ----------------------------------------------------------------------------
module gcp_checker import gcp_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             push,
	input wire logic             full,
	input wire logic             empty,
	input wire logic             pop,
	input wire logic [SUM_W-1:0] min_cost
);

	logic in_xact;

	assign in_xact = push && !full;

	// Hold a waiting result until it is taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(min_cost)))
		else $error("waiting result changed or vanished before pop");

	// Block input only while results back up
	a_full_needs_results: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("input blocked with no result waiting");

	// Drain: with no input transaction and no result through the whole antecedent,
	// nothing is left in flight that could produce a result
	a_no_phantom_result: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !in_xact) ##1 (empty && !in_xact) ##1
		(empty && !in_xact) ##1 (empty && !in_xact) |=> empty)
		else $error("result appeared without a matching input transaction");

endmodule

bind grid_min_cost_path_core gcp_checker u_gcp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.full     (full),
	.empty    (empty),
	.pop      (pop),
	.min_cost (min_cost)
);

`default_nettype wire

// ===== tb/grid_min_cost_path_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_min_cost_path_core_tb: self-checking bench for the grid path core
// Streams cost grids of many shapes through the core. Shapes include
// degenerate, saturated and resized-mid-grid cases. A path-sum tracker
// predicts each grid answer, and every popped answer is compared in order.
// ----------------------------------------------------------------------------
module grid_min_cost_path_core_tb;
	import gcp_pkg::*;

	localparam int GRID_MAX_COLS = 256;
	localparam int GRID_MAX_ROWS = 1024;
	localparam int DRAIN_CYCLES  = 16;
	localparam int RANDOM_CELLS  = 420;

	typedef enum int {COST_ANY, COST_NEAR_ZERO, COST_EDGE, COST_POSITIVE} cost_mix_t;
	typedef enum int {SHAPE_SMALL, SHAPE_WIDE, SHAPE_TALL, SHAPE_DEGENERATE} grid_shape_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     push      = 1'b0;
	logic                     full;
	logic signed [COST_W-1:0] cell_cost = '0;
	logic                     empty;
	logic                     pop       = 1'b0;
	logic signed [SUM_W-1:0]  min_cost;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_GRID_ROWS;
	logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

	// Cells waiting to be pushed, answers waiting to be popped
	logic signed [COST_W-1:0] cell_q[$];
	logic signed [SUM_W-1:0]  min_cost_q[$];

	// Tracker copy of the sizes and the running path sums
	logic [ROWS_CFG_W-1:0]    rows_reg = 11'd1;
	logic [COLS_CFG_W-1:0]    cols_reg = 9'd1;
	logic signed [SUM_W-1:0]  prev_row[GRID_MAX_COLS];
	logic signed [SUM_W-1:0]  left_acc = '0;
	logic signed [SUM_W-1:0]  diag_acc = '0;
	int unsigned              row_at = 0;
	int unsigned              col_at = 0;

	int unsigned              in_gap = 0;
	int unsigned              out_hold = 0;
	int unsigned              out_next;
	bit                       in_burst = 1'b0;
	bit                       out_burst = 1'b0;
	logic signed [SUM_W-1:0]  answer_exp;
	int                       errors = 0;
	int                       cells_queued = 0;
	int                       cells_taken = 0;
	int                       answers_checked = 0;
	int                       reg_writes = 0;

	grid_min_cost_path_core #(
		.MAX_COLS(GRID_MAX_COLS),
		.MAX_ROWS(GRID_MAX_ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.cell_cost(cell_cost),
		.empty(empty),
		.pop(pop),
		.min_cost(min_cost),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial forever #6 clk = ~clk;

	// Zero acts as one; anything past the bound saturates
	function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// Fold one cell into the running sums; queue the answer at the grid's end
	task automatic accumulate_cell(input logic signed [COST_W-1:0] cost);
		int unsigned             n_rows;
		int unsigned             n_cols;
		logic signed [SUM_W-1:0] cost_ext;
		logic signed [SUM_W-1:0] up;
		logic signed [SUM_W-1:0] best;
		logic signed [SUM_W-1:0] sum;
		n_rows = clamp_dim(32'(rows_reg), GRID_MAX_ROWS);
		n_cols = clamp_dim(32'(cols_reg), GRID_MAX_COLS);
		cost_ext = SUM_W'(cost);
		up = prev_row[col_at];
		if (row_at == 0 && col_at == 0) begin
			sum = cost_ext;
		end else if (row_at == 0) begin
			sum = left_acc + cost_ext;
		end else if (col_at == 0) begin
			sum = up + cost_ext;
		end else begin
			best = left_acc;
			if (up < best) best = up;
			if (diag_acc < best) best = diag_acc;
			sum = best + cost_ext;
		end
		diag_acc = up;
		prev_row[col_at] = sum;
		left_acc = sum;
		if (col_at + 1 >= n_cols) begin
			col_at = 0;
			if (row_at + 1 >= n_rows) begin
				row_at = 0;
				min_cost_q.push_back(sum);
			end else begin
				row_at++;
			end
		end else begin
			col_at++;
		end
	endtask

	// Count the cells still needed to close the grid under the current sizes
	function automatic int unsigned cells_to_grid_end();
		int unsigned n_rows;
		int unsigned n_cols;
		int unsigned r;
		int unsigned c;
		int unsigned n;
		bit          done;
		n_rows = clamp_dim(32'(rows_reg), GRID_MAX_ROWS);
		n_cols = clamp_dim(32'(cols_reg), GRID_MAX_COLS);
		r = row_at;
		c = col_at;
		n = 0;
		done = 1'b0;
		while (!done) begin
			n++;
			if (c + 1 >= n_cols) begin
				c = 0;
				if (r + 1 >= n_rows) done = 1'b1;
				else r++;
			end else begin
				c++;
			end
		end
		return n;
	endfunction

	function automatic logic signed [COST_W-1:0] draw_cost(input cost_mix_t mix);
		int v;
		case (mix)
			COST_NEAR_ZERO: v = $urandom_range(0, 40) - 20;
			COST_EDGE: begin
				case ($urandom_range(0, 3))
					0: v = -32768;
					1: v = 32767;
					2: v = -1;
					default: v = 0;
				endcase
			end
			COST_POSITIVE: v = $urandom_range(0, 32767);
			default: v = $urandom;
		endcase
		return v[COST_W-1:0];
	endfunction

	task automatic queue_cell(input logic signed [COST_W-1:0] cost);
		cell_q.push_back(cost);
		cells_queued++;
	endtask

	// Wait until every cell is taken and every answer popped, then let the pipe drain
	task automatic settle();
		while (cells_taken != cells_queued || min_cost_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_GRID_ROWS) rows_reg = val[ROWS_CFG_W-1:0];
		else cols_reg = val[COLS_CFG_W-1:0];
		reg_writes++;
	endtask

	// Change grid sizes once the core has gone quiet
	task automatic resize_grid(input bit set_rows, input logic [CFG_DATA_W-1:0] rows_v,
	                           input bit set_cols, input logic [CFG_DATA_W-1:0] cols_v);
		settle();
		if (set_rows) write_reg(REG_GRID_ROWS, rows_v);
		if (set_cols) write_reg(REG_GRID_COLS, cols_v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: present queued cells, predict each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push   <= 1'b0;
			in_gap <= 0;
		end else begin
			if (push && !full) begin
				accumulate_cell(cell_cost);
				cells_taken++;
			end
			if (!push || !full) begin
				if (in_gap != 0) begin
					push   <= 1'b0;
					in_gap <= in_gap - 1;
				end else if (cell_q.size() != 0) begin
					push      <= 1'b1;
					cell_cost <= cell_q.pop_front();
					in_gap    <= in_burst ? 0 : $urandom_range(0, 8);
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// Monitor: pop answers with random stalls and compare against the tracker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop      <= 1'b0;
			out_hold <= 0;
		end else begin
			if (pop && !empty) begin
				if (min_cost_q.size() == 0) begin
					$error("min_cost: unexpected transaction, actual %0d", min_cost);
					errors++;
				end else begin
					answer_exp = min_cost_q.pop_front();
					if (min_cost !== answer_exp) begin
						$error("min_cost: expected %0d, actual %0d", answer_exp, min_cost);
						errors++;
					end
					answers_checked++;
				end
				out_next = out_burst ? 0 : $urandom_range(0, 8);
			end else begin
				out_next = (out_hold != 0) ? out_hold - 1 : 0;
			end
			out_hold <= out_next;
			pop      <= (out_next == 0);
		end
	end

	initial begin
		int unsigned           rv;
		int unsigned           cv;
		int unsigned           grids;
		int unsigned           total;
		int unsigned           pick;
		int unsigned           random_cells;
		bit                    set_r;
		bit                    set_c;
		grid_shape_t           shape;
		cost_mix_t             mix;
		logic [CFG_DATA_W-1:0] cols_word;

		for (int i = 0; i < GRID_MAX_COLS; i++) prev_row[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes are 1x1: every cell is a grid of its own
		queue_cell(16'sh8000);
		queue_cell(16'sh7fff);
		queue_cell(16'sh0000);
		queue_cell(16'shffff);
		queue_cell(16'sh0001);

		// 2x2: cheap diagonal, then extremes on every corner
		resize_grid(1'b1, 11'd2, 1'b1, 11'd2);
		queue_cell(16'sd1);
		queue_cell(16'sd100);
		queue_cell(16'sd100);
		queue_cell(16'sd1);
		queue_cell(16'sh7fff);
		queue_cell(16'sh8000);
		queue_cell(16'sh8000);
		queue_cell(16'sh7fff);

		// Zero sizes behave as one
		resize_grid(1'b1, 11'd0, 1'b1, 11'd0);
		queue_cell(-16'sd5);
		queue_cell(16'sd9);

		// 3x3 with mixed signs
		resize_grid(1'b1, 11'd3, 1'b1, 11'd3);
		queue_cell(16'sd4);
		queue_cell(-16'sd2);
		queue_cell(16'sd9);
		queue_cell(16'sd1);
		queue_cell(16'sd7);
		queue_cell(-16'sd8);
		queue_cell(16'sd3);
		queue_cell(16'sd3);
		queue_cell(16'sd2);

		// Saturated width over one row; this also fills every row buffer entry
		resize_grid(1'b1, 11'd1, 1'b1, 11'h7ff);
		for (int i = 0; i < GRID_MAX_COLS; i++) queue_cell(draw_cost(COST_ANY));

		// Random shapes, some grids cut short and resized mid-way
		random_cells = 0;
		while (random_cells < RANDOM_CELLS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) shape = SHAPE_SMALL;
			else if (pick == 6) shape = SHAPE_WIDE;
			else if (pick == 7) shape = SHAPE_TALL;
			else shape = SHAPE_DEGENERATE;
			case (shape)
				SHAPE_WIDE: begin
					rv = $urandom_range(1, 3);
					cv = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 511)
					                                 : $urandom_range(7, 64);
				end
				SHAPE_TALL: begin
					rv = $urandom_range(7, 48);
					cv = $urandom_range(1, 3);
				end
				SHAPE_DEGENERATE: begin
					rv = $urandom_range(0, 3);
					cv = $urandom_range(0, 3);
				end
				default: begin
					rv = $urandom_range(1, 6);
					cv = $urandom_range(1, 6);
				end
			endcase
			// Touch only one register when the other size keeps the grid small
			pick  = $urandom_range(0, 3);
			set_r = !(pick == 1 && clamp_dim(32'(rows_reg), GRID_MAX_ROWS) <= 8);
			set_c = !(pick == 0 && clamp_dim(32'(cols_reg), GRID_MAX_COLS) <= 8);
			cols_word = {2'($urandom), 9'(cv)};
			in_burst  = ($urandom_range(0, 3) == 0);
			out_burst = ($urandom_range(0, 3) == 0);
			resize_grid(set_r, 11'(rv), set_c, cols_word);

			grids = $urandom_range(1, 4);
			total = cells_to_grid_end() + (grids - 1) * clamp_dim(32'(rows_reg), GRID_MAX_ROWS)
			        * clamp_dim(32'(cols_reg), GRID_MAX_COLS);
			if ($urandom_range(0, 4) == 0 && total > 1) total = $urandom_range(1, total - 1);
			// Clip to the remaining cell budget; a clipped grid goes on after the next resize
			if (total > RANDOM_CELLS - random_cells) total = RANDOM_CELLS - random_cells;
			mix = cost_mix_t'($urandom_range(0, 3));
			for (int i = 0; i < total; i++) queue_cell(draw_cost(mix));
			random_cells += total;
		end

		settle();
		$display("streamed %0d cells over %0d register writes; %0d grid answers compared",
		         cells_taken, reg_writes, answers_checked);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", errors);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
